/* rtl/core/mbe_pkg.sv */
// Shared constants and types for the Mandelbrot escape-time block.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int WORD_BITS             = 32;   // c and z components
  localparam int LIMIT_BITS            = 16;   // iteration_limit register
  localparam int OUT_BITS              = 16;   // escape_count field
  localparam int FRACTION_BITS_DEFAULT = 28;
  localparam int COUNT_BITS_DEFAULT    = 16;
  localparam int QUEUE_DEPTH_DEFAULT   = 2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } iter_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/core/mbe_queue.sv */
// Small register FIFO between the front and back halves of the block.
// Depends on mbe_pkg (queue_status_t).
`timescale 1ns / 1ps

module mbe_queue #(
  parameter int WIDTH = 80,
  parameter int DEPTH = mbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output mbe_pkg::queue_status_t status
);
  import mbe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;

  assign status.full  = (fill == FW'(DEPTH));
  assign status.empty = (fill == '0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FW'(DEPTH))
    else $error("queue fill above depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
      push && !pop |-> fill < FW'(DEPTH))
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> fill != '0)
    else $error("pop from empty queue");
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> fill == $past(fill) + 1'b1)
    else $error("fill did not advance on push");
`endif

endmodule

/* rtl/core/mbe_front.sv */
// Front half: limit register, input acceptance, limit clipping, queue push.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_front #(
  parameter int COUNT_BITS = mbe_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mbe_pkg::LIMIT_BITS-1:0]           iteration_limit,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [mbe_pkg::WORD_BITS-1:0]     c_real,
  input  logic signed [mbe_pkg::WORD_BITS-1:0]     c_imag,
  input  mbe_pkg::queue_status_t                   q_status,
  output logic                                     q_push,
  output logic [2*mbe_pkg::WORD_BITS+COUNT_BITS-1:0] q_data
);
  import mbe_pkg::*;

  logic [LIMIT_BITS-1:0] limit;
  logic [COUNT_BITS-1:0] limit_eff;

  // limit clipped to the counter range
  always_comb begin
    if (COUNT_BITS >= LIMIT_BITS) begin
      limit_eff = COUNT_BITS'(limit);
    end else if ((32'(limit) >> COUNT_BITS) != 32'd0) begin
      limit_eff = '1;
    end else begin
      limit_eff = COUNT_BITS'(limit);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;
  assign q_push    = in_valid && !q_status.full;
  assign q_data    = {c_real, c_imag, limit_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= iteration_limit;
    end
  end

endmodule

/* rtl/core/mbe_core.sv */
// Back half: iterates z = z*z + c with three 32x32 multipliers in a multiply
// state and an update state, and holds the result register. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_core #(
  parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEFAULT,
  parameter int COUNT_BITS    = mbe_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  mbe_pkg::queue_status_t                     q_status,
  input  logic [2*mbe_pkg::WORD_BITS+COUNT_BITS-1:0] q_data,
  output logic                                       q_pop,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [mbe_pkg::OUT_BITS-1:0]               escape_count
);
  import mbe_pkg::*;

  localparam int EW        = 2 * WORD_BITS + COUNT_BITS;
  localparam int ESC_SHIFT = 2 * FRACTION_BITS + 2;
  localparam bit ESC_ON    = (ESC_SHIFT < 2 * WORD_BITS);
  localparam int ESC_LO    = ESC_ON ? ESC_SHIFT : 2 * WORD_BITS - 1;

  function automatic logic signed [WORD_BITS-1:0] clip_word(
      input logic signed [2*WORD_BITS-1:0] v);
    logic [WORD_BITS:0] top;
    top = v[2*WORD_BITS-1:WORD_BITS-1];
    if ((top == '0) || (top == '1)) begin
      return v[WORD_BITS-1:0];
    end
    return v[2*WORD_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                            : {1'b0, {(WORD_BITS-1){1'b1}}};
  endfunction

  iter_state_t state, state_next;

  logic signed [WORD_BITS-1:0]   c_re, c_im, x, y;
  logic [COUNT_BITS-1:0]         lim, cnt;
  logic signed [2*WORD_BITS-1:0] sq_x, sq_y, pr_xy;
  logic [OUT_BITS-1:0]           res;
  logic                          res_valid;

  logic [2*WORD_BITS-1:0]        mag_sum;
  logic signed [2*WORD_BITS-1:0] diff, nx_w, ny_w;
  logic                          escaped, finish, res_load, step;

  // datapath of the update cycle
  always_comb begin
    mag_sum = unsigned'(sq_x) + unsigned'(sq_y);
    escaped = ESC_ON && ((mag_sum >> ESC_LO) != '0);
    finish  = (cnt >= lim) || escaped;
    diff    = sq_x - sq_y;
    nx_w    = (diff >>> FRACTION_BITS) + (2*WORD_BITS)'(c_re);
    ny_w    = (pr_xy >>> (FRACTION_BITS - 1)) + (2*WORD_BITS)'(c_im);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_UPD;
      ST_UPD: begin
        if (!finish) begin
          state_next = ST_MUL;
        end else if (!res_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    res_load = 1'b0;
    step     = 1'b0;
    case (state)
      ST_IDLE: q_pop = !q_status.empty;
      ST_UPD: begin
        step     = !finish;
        res_load = finish && (!res_valid || out_ready);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      c_re <= q_data[EW-1 -: WORD_BITS];
      c_im <= q_data[EW-WORD_BITS-1 -: WORD_BITS];
      lim  <= q_data[COUNT_BITS-1:0];
      x    <= '0;
      y    <= '0;
      cnt  <= '0;
    end
    if (state == ST_MUL) begin
      sq_x  <= (2*WORD_BITS)'(x) * (2*WORD_BITS)'(x);
      sq_y  <= (2*WORD_BITS)'(y) * (2*WORD_BITS)'(y);
      pr_xy <= (2*WORD_BITS)'(x) * (2*WORD_BITS)'(y);
    end
    if (step) begin
      x   <= clip_word(nx_w);
      y   <= clip_word(ny_w);
      cnt <= cnt + 1'b1;
    end
    if (res_load) begin
      res <= OUT_BITS'(cnt);
    end
  end

  assign out_valid    = res_valid;
  assign escape_count = res;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
      state != ST_IDLE |-> cnt <= lim)
    else $error("iteration count passed the limit");
  a_finish_cause: assert property (@(posedge clk) disable iff (rst)
      res_load |-> (cnt == lim) || escaped)
    else $error("result written without escape or limit");
  a_mul_then_upd: assert property (@(posedge clk) disable iff (rst)
      state == ST_MUL |=> state == ST_UPD)
    else $error("multiply cycle not followed by update");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |=> state == ST_MUL && cnt == '0)
    else $error("new point did not start cleanly");
`endif

endmodule

/* rtl/core/mandelbrot_escape_time.sv */
// Top level of the Mandelbrot escape-time counter.
// Depends on mbe_pkg, mbe_front, mbe_queue and mbe_core.
`timescale 1ns / 1ps

//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  cfg     | cfg_valid / cfg_ready | iteration_limit [15:0]
//  in      | in_valid  / in_ready  | c_real [31:0], c_imag [31:0]
//  out     | out_valid / out_ready | escape_count [15:0]
//
//  In the back half a point is popped from the queue in the idle state, then
//  each pass runs a multiply state (three 32x32 products) and an update
//  state (escape test, z*z + c, saturation).
//  Reset (rst, synchronous) sets the limit to 255 and empties the queue.
//  cfg_ready is always high; in_ready drops only when the queue is full.
//  A result stalled at out holds the back half in its final update cycle
//  while the front keeps filling the queue.

module mandelbrot_escape_time #(
  parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEFAULT,
  parameter int COUNT_BITS    = mbe_pkg::COUNT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH   = mbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbe_pkg::LIMIT_BITS-1:0]       iteration_limit,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mbe_pkg::WORD_BITS-1:0] c_real,
  input  logic signed [mbe_pkg::WORD_BITS-1:0] c_imag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mbe_pkg::OUT_BITS-1:0]         escape_count
);
  import mbe_pkg::*;

  // queue entry: {c_real, c_imag, clipped limit}
  localparam int EW = 2 * WORD_BITS + COUNT_BITS;

  queue_status_t q_status;
  logic          q_push, q_pop;
  logic [EW-1:0] q_wdata, q_rdata;

  mbe_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .iteration_limit (iteration_limit),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  mbe_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .status    (q_status)
  );

  // back half: iteration loop and result register
  mbe_core #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count)
  );

endmodule
